[hw/rtl/spwm_pkg.sv]
// Package for the sinusoidal PWM phase/duty pipeline: widths, register codes,
// payload and inter-stage types, and the quarter-wave sine table built at elaboration.
// No dependencies.
package spwm_pkg;

	localparam int ANGLE_BITS       = 12;
	localparam int SINE_TABLE_DEPTH = 1024;
	localparam int DEPTH_BITS       = $clog2(SINE_TABLE_DEPTH);
	localparam int QUARTER_BITS     = DEPTH_BITS - 2;
	localparam int QUARTER          = SINE_TABLE_DEPTH / 4;

	localparam int PPC_W      = 7;
	localparam int VS_W       = 15;
	localparam int LIM_W      = 15;
	localparam int PER_W      = 17;
	localparam int UQ_W       = 16;
	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 17;

	localparam logic [PPC_W-1:0] PPC_RESET = PPC_W'(7);
	localparam logic [VS_W-1:0]  VS_RESET  = VS_W'(3072);
	localparam logic [LIM_W-1:0] LIM_RESET = LIM_W'(3072);
	localparam logic [PER_W-1:0] PER_RESET = PER_W'(65536);

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_POLE_PAIRS  = 3'd0,
		REG_ELEC_OFFSET = 3'd1,
		REG_SUPPLY      = 3'd2,
		REG_LIMIT       = 3'd3,
		REG_PERIOD      = 3'd4
	} cfg_reg_t;

	// sine magnitude Q15 (1.0 = 32768), signed sine one bit wider
	localparam int QSIN_W = 16;
	localparam int SIN_W  = 17;

	// working scale: half of the doubled phase voltage, 2^34 per volt
	localparam int PROD_W      = UQ_W + SIN_W;
	localparam int SQRT3_HALF  = 3547;
	localparam int SQ3_W       = 12;
	localparam int TERM_W      = PROD_W + SQ3_W;
	localparam int H_W         = TERM_W + 2;
	localparam int ALPHA_SHIFT = 12;
	localparam int BETA_SHIFT  = 11;
	localparam int VS_SHIFT    = 27;
	localparam int HC_W        = LIM_W + VS_SHIFT;
	localparam int LO_W        = HC_W / 2;
	localparam int HI_W        = HC_W - LO_W;
	localparam int NUM_W       = HC_W + PER_W + 1;
	localparam int NQ_W        = NUM_W - VS_SHIFT;
	localparam int QUOT_W      = PER_W;
	localparam int LANES       = 3;

	localparam int FRONT_STAGES = 3;
	localparam int PHASE_STAGES = 5;
	localparam int PIPE_LATENCY = FRONT_STAGES + PHASE_STAGES + QUOT_W + 1;

	localparam longint SC1 = 1686629713;
	localparam longint SC3 = 693598668;
	localparam longint SC5 = 85569304;
	localparam longint SC7 = 5026995;
	localparam longint SC9 = 172273;

	typedef struct packed {
		logic [ANGLE_BITS-1:0]  rotor_angle;
		logic signed [UQ_W-1:0] quadrature_voltage;
	} item_t;

	typedef struct packed {
		logic [PER_W-1:0] compare_a;
		logic [PER_W-1:0] compare_b;
		logic [PER_W-1:0] compare_c;
	} result_t;

	typedef struct packed {
		logic [PPC_W-1:0] pole_pair_count;
		logic [VS_W-1:0]  supply_voltage;
		logic [LIM_W-1:0] phase_voltage_limit;
		logic [PER_W-1:0] pwm_period;
	} cfg_t;

	typedef struct packed {
		logic signed [PROD_W-1:0] p;    // Uq * sin
		logic signed [PROD_W-1:0] q;    // Uq * cos
	} prod_t;

	typedef struct packed {
		logic [NQ_W-1:0] num;
		logic            sat;
	} lane_t;

	typedef logic [QUARTER:0][QSIN_W-1:0] qsin_tab_t;

	// odd degree-9 polynomial for sin(pi/2 * u), Q30, rounded to Q15
	function automatic qsin_tab_t build_qsin();
		qsin_tab_t tab;
		longint    u;
		longint    u2;
		longint    r;
		longint    s;
		tab = '0;
		for (int j = 0; j <= QUARTER; j++) begin
			u  = (longint'(j) <<< 30) / QUARTER;
			u2 = (u * u) >>> 30;
			r  = SC9;
			r  = SC7 - ((u2 * r) >>> 30);
			r  = SC5 - ((u2 * r) >>> 30);
			r  = SC3 - ((u2 * r) >>> 30);
			r  = SC1 - ((u2 * r) >>> 30);
			s  = (((u * r) >>> 30) + 16384) >>> 15;
			if (s > 32768) begin
				s = 32768;
			end
			tab[j] = QSIN_W'(s);
		end
		return tab;
	endfunction

	localparam qsin_tab_t QSIN_TAB = build_qsin();

	function automatic logic signed [SIN_W-1:0] table_sine(input logic [DEPTH_BITS-1:0] k);
		logic [1:0]              quad;
		logic [QUARTER_BITS-1:0] j;
		logic [QUARTER_BITS:0]   idx;
		logic [SIN_W-1:0]        mag;
		quad = k[DEPTH_BITS-1 -: 2];
		j    = k[QUARTER_BITS-1:0];
		idx  = quad[0] ? ((QUARTER_BITS+1)'(QUARTER) - {1'b0, j}) : {1'b0, j};
		mag  = {1'b0, QSIN_TAB[idx]};
		return quad[1] ? -$signed(mag) : $signed(mag);
	endfunction

endpackage

[hw/rtl/spwm_cfg.sv]
// Configuration register file of the sinusoidal PWM block.
// Depends on spwm_pkg.
module spwm_cfg (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              cfg_valid,
	output logic                              cfg_ready,
	input  logic [spwm_pkg::CFG_IDX_W-1:0]    cfg_index,
	input  logic [spwm_pkg::CFG_DATA_W-1:0]   cfg_data,
	output spwm_pkg::cfg_t                    cfg
);
	import spwm_pkg::*;

	logic [PPC_W-1:0] ppc_q;
	logic [VS_W-1:0]  vs_q;
	logic [LIM_W-1:0] lim_q;
	logic [PER_W-1:0] per_q;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ppc_q <= PPC_RESET;
			vs_q  <= VS_RESET;
			lim_q <= LIM_RESET;
			per_q <= PER_RESET;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				REG_POLE_PAIRS:  ppc_q <= cfg_data[PPC_W-1:0];
				REG_ELEC_OFFSET: ;  // offset is subtracted and re-added: no effect
				REG_SUPPLY:      vs_q  <= cfg_data[VS_W-1:0];
				REG_LIMIT:       lim_q <= cfg_data[LIM_W-1:0];
				REG_PERIOD:      per_q <= cfg_data[PER_W-1:0];
				default:         ;
			endcase
		end
	end

	assign cfg.pole_pair_count     = ppc_q;
	assign cfg.supply_voltage      = vs_q;
	assign cfg.phase_voltage_limit = lim_q;
	assign cfg.pwm_period          = per_q;

endmodule

[hw/rtl/spwm_front.sv]
// Front stages s1..s3: electrical angle, sine/cosine lookup, Uq products.
// Depends on spwm_pkg.
module spwm_front (
	input  logic              clk,
	input  logic              arst_n,
	input  spwm_pkg::cfg_t    cfg,
	input  logic              in_valid,
	input  spwm_pkg::item_t   item,
	output logic              valid_s3,
	output spwm_pkg::prod_t   prod_s3
);
	import spwm_pkg::*;

	localparam int KX_W = ANGLE_BITS + DEPTH_BITS;

	logic [PPC_W+ANGLE_BITS-1:0] e_full;
	logic [ANGLE_BITS-1:0]       e_s1;
	logic signed [UQ_W-1:0]      uq_s1;
	logic signed [UQ_W-1:0]      uq_s2;
	logic [KX_W-1:0]             kx;
	logic [DEPTH_BITS-1:0]       k;
	logic signed [SIN_W-1:0]     sin_s2;
	logic signed [SIN_W-1:0]     cos_s2;
	logic                        valid_s1;
	logic                        valid_s2;

	assign e_full = (PPC_W+ANGLE_BITS)'(cfg.pole_pair_count)
		* (PPC_W+ANGLE_BITS)'(item.rotor_angle);
	assign kx = {e_s1, {DEPTH_BITS{1'b0}}} >> ANGLE_BITS;
	assign k  = kx[DEPTH_BITS-1:0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			valid_s3 <= 1'b0;
		end else begin
			valid_s1 <= in_valid;
			valid_s2 <= valid_s1;
			valid_s3 <= valid_s2;
		end
	end

	always_ff @(posedge clk) begin
		e_s1      <= e_full[ANGLE_BITS-1:0];
		uq_s1     <= item.quadrature_voltage;
		sin_s2    <= table_sine(k);
		cos_s2    <= table_sine(k + DEPTH_BITS'(QUARTER));
		uq_s2     <= uq_s1;
		prod_s3.p <= uq_s2 * sin_s2;
		prod_s3.q <= uq_s2 * cos_s2;
	end

endmodule

[hw/rtl/spwm_phase.sv]
// Phase stages s4..s8: inverse Clarke, clamp, saturation flag, scaling by the
// period and the rounding offset ahead of the divider. Depends on spwm_pkg.
module spwm_phase (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  spwm_pkg::cfg_t                        cfg,
	input  logic                                  valid_s3,
	input  spwm_pkg::prod_t                       prod_s3,
	output logic                                  valid_s8,
	output spwm_pkg::lane_t [spwm_pkg::LANES-1:0] lane_s8
);
	import spwm_pkg::*;

	logic signed [PROD_W-1:0] p_s4;
	logic signed [TERM_W-1:0] t_s4;
	logic signed [H_W-1:0]    vs_h;
	logic signed [H_W-1:0]    pa;
	logic signed [H_W-1:0]    ta;
	logic signed [H_W-1:0]    h      [LANES];
	logic signed [H_W-1:0]    h_s5   [LANES];
	logic [HC_W-1:0]          lim_c;
	logic signed [H_W-1:0]    lim_h;
	logic [HC_W-1:0]          vs_c;
	logic [HC_W-1:0]          hcl    [LANES];
	logic                     sat    [LANES];
	logic [HC_W-1:0]          hcl_s6 [LANES];
	logic                     sat_s6 [LANES];
	logic [HI_W+PER_W-1:0]    hi_s7  [LANES];
	logic [LO_W+PER_W-1:0]    lo_s7  [LANES];
	logic                     sat_s7 [LANES];
	logic [NUM_W-1:0]         num    [LANES];
	logic                     valid_s4;
	logic                     valid_s5;
	logic                     valid_s6;
	logic                     valid_s7;

	assign vs_h  = $signed(H_W'(cfg.supply_voltage) << (VS_SHIFT - 1));
	assign pa    = H_W'(p_s4);
	assign ta    = H_W'(t_s4);
	assign h[0]  = vs_h - (pa <<< ALPHA_SHIFT);
	assign h[1]  = vs_h + (pa <<< BETA_SHIFT) + ta;
	assign h[2]  = vs_h + (pa <<< BETA_SHIFT) - ta;

	assign lim_c = HC_W'(cfg.phase_voltage_limit) << VS_SHIFT;
	assign lim_h = $signed(H_W'(lim_c));
	assign vs_c  = HC_W'(cfg.supply_voltage) << VS_SHIFT;

	always_comb begin
		for (int i = 0; i < LANES; i++) begin
			unique if (h_s5[i] < 0) begin
				hcl[i] = '0;
			end else if (h_s5[i] > lim_h) begin
				hcl[i] = lim_c;
			end else begin
				hcl[i] = h_s5[i][HC_W-1:0];
			end
			sat[i] = (hcl[i] >= vs_c);
		end
	end

	always_comb begin
		for (int i = 0; i < LANES; i++) begin
			num[i] = (NUM_W'(hi_s7[i]) << LO_W) + NUM_W'(lo_s7[i])
				+ (NUM_W'(cfg.supply_voltage) << (VS_SHIFT - 1));
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s4 <= 1'b0;
			valid_s5 <= 1'b0;
			valid_s6 <= 1'b0;
			valid_s7 <= 1'b0;
			valid_s8 <= 1'b0;
		end else begin
			valid_s4 <= valid_s3;
			valid_s5 <= valid_s4;
			valid_s6 <= valid_s5;
			valid_s7 <= valid_s6;
			valid_s8 <= valid_s7;
		end
	end

	always_ff @(posedge clk) begin
		p_s4 <= prod_s3.p;
		t_s4 <= prod_s3.q * TERM_W'(SQRT3_HALF);
		for (int i = 0; i < LANES; i++) begin
			h_s5[i]        <= h[i];
			hcl_s6[i]      <= hcl[i];
			sat_s6[i]      <= sat[i];
			hi_s7[i]       <= hcl_s6[i][HC_W-1:LO_W] * cfg.pwm_period;
			lo_s7[i]       <= hcl_s6[i][LO_W-1:0] * cfg.pwm_period;
			sat_s7[i]      <= sat_s6[i];
			lane_s8[i].num <= num[i][NUM_W-1:VS_SHIFT];
			lane_s8[i].sat <= sat_s7[i];
		end
	end

endmodule

[hw/rtl/spwm_div.sv]
// Pipelined restoring divider, one quotient bit per stage for three lanes,
// followed by the output register with saturation select. Depends on spwm_pkg.
module spwm_div (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  spwm_pkg::cfg_t                        cfg,
	input  logic                                  valid_s8,
	input  spwm_pkg::lane_t [spwm_pkg::LANES-1:0] lane_s8,
	output logic                                  done,
	output spwm_pkg::result_t                     result
);
	import spwm_pkg::*;

	typedef struct packed {
		logic [NQ_W-1:0]   rem;
		logic [QUOT_W-1:0] quo;
		logic              sat;
	} dlane_t;

	dlane_t [LANES-1:0] div_s [1:QUOT_W];
	logic               div_v [1:QUOT_W];
	logic [PER_W-1:0]   pick  [LANES];
	result_t            result_q;
	logic               done_q;

	for (genvar g = 0; g < QUOT_W; g++) begin : g_bit
		localparam int B = QUOT_W - 1 - g;
		dlane_t [LANES-1:0] cur;
		dlane_t [LANES-1:0] nxt;
		logic [NQ_W-1:0]    dvs;
		logic               cur_v;

		assign dvs = NQ_W'(cfg.supply_voltage) << B;

		if (g == 0) begin : g_head
			always_comb begin
				for (int i = 0; i < LANES; i++) begin
					cur[i].rem = lane_s8[i].num;
					cur[i].quo = '0;
					cur[i].sat = lane_s8[i].sat;
				end
			end
			assign cur_v = valid_s8;
		end else begin : g_tail
			assign cur   = div_s[g];
			assign cur_v = div_v[g];
		end

		always_comb begin
			nxt = cur;
			for (int i = 0; i < LANES; i++) begin
				if (cur[i].rem >= dvs) begin
					nxt[i].rem    = cur[i].rem - dvs;
					nxt[i].quo[B] = 1'b1;
				end
			end
		end

		always_ff @(posedge clk) begin
			div_s[g+1] <= nxt;
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				div_v[g+1] <= 1'b0;
			end else begin
				div_v[g+1] <= cur_v;
			end
		end
	end

	always_comb begin
		for (int i = 0; i < LANES; i++) begin
			priority if (cfg.supply_voltage == '0) begin
				pick[i] = '0;
			end else if (div_s[QUOT_W][i].sat) begin
				pick[i] = cfg.pwm_period;
			end else begin
				pick[i] = div_s[QUOT_W][i].quo;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done_q <= 1'b0;
		end else begin
			done_q <= div_v[QUOT_W];
		end
	end

	always_ff @(posedge clk) begin
		result_q.compare_a <= pick[0];
		result_q.compare_b <= pick[1];
		result_q.compare_c <= pick[2];
	end

	assign done   = done_q;
	assign result = result_q;

endmodule

[hw/rtl/sine_pwm_phase_duty_top.sv]
// Top level of the sinusoidal PWM phase/duty generator.
// Depends on spwm_pkg, spwm_cfg, spwm_front, spwm_phase, spwm_div.
//
// Takes one item per clock: busy stays low, so start transfers an item at every
// edge where it is high. Each item comes out as three compare values with a
// one-cycle done strobe; results cannot be held off. The pipeline is
// three front stages (angle, sine lookup, Uq products), five phase
// stages (Clarke, clamp, period scaling) and a 17-stage restoring divider, one
// quotient bit per stage, plus the output register. Configuration is taken at
// every edge where cfg_valid is high and should only change while no item is in
// flight; electrical_offset is accepted but has no effect.
module sine_pwm_phase_duty_top (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             start,
	output logic                             busy,
	input  spwm_pkg::item_t                  item,
	output logic                             done,
	output spwm_pkg::result_t                result,
	input  logic                             cfg_valid,
	output logic                             cfg_ready,
	input  logic [spwm_pkg::CFG_IDX_W-1:0]   cfg_index,
	input  logic [spwm_pkg::CFG_DATA_W-1:0]  cfg_data
);
	import spwm_pkg::*;

	cfg_t               cfg;
	logic               in_valid;
	logic               valid_s3;
	prod_t              prod_s3;
	logic               valid_s8;
	lane_t [LANES-1:0]  lane_s8;

	assign busy     = 1'b0;
	assign in_valid = start && !busy;

	spwm_cfg u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cfg       (cfg)
	);

	spwm_front u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg      (cfg),
		.in_valid (in_valid),
		.item     (item),
		.valid_s3 (valid_s3),
		.prod_s3  (prod_s3)
	);

	spwm_phase u_phase (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg      (cfg),
		.valid_s3 (valid_s3),
		.prod_s3  (prod_s3),
		.valid_s8 (valid_s8),
		.lane_s8  (lane_s8)
	);

	spwm_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg      (cfg),
		.valid_s8 (valid_s8),
		.lane_s8  (lane_s8),
		.done     (done),
		.result   (result)
	);

endmodule

[hw/rtl/spwm_chk.sv]
// Port-level checker for sine_pwm_phase_duty_top, attached by bind.
// Depends on spwm_pkg.
module spwm_chk (
	input logic              clk,
	input logic              arst_n,
	input logic              start,
	input logic              busy,
	input spwm_pkg::item_t   item,
	input logic              done,
	input spwm_pkg::result_t result
);
	import spwm_pkg::*;

	logic accept;

	assign accept = start && !busy;

	a_latency: assert property (@(posedge clk) disable iff (!arst_n)
		accept |-> ##PIPE_LATENCY done)
		else $error("transfer without result at fixed latency");

	a_no_extra: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(accept, PIPE_LATENCY))
		else $error("result without matching transfer");

	a_zero_uq: assert property (@(posedge clk) disable iff (!arst_n)
		(accept && item.quadrature_voltage == '0) |-> ##PIPE_LATENCY
		(result.compare_a == result.compare_b && result.compare_a == result.compare_c))
		else $error("zero Uq gave unequal phases");

endmodule

bind sine_pwm_phase_duty_top spwm_chk u_spwm_chk (.*);

[tb/sv/tb.sv]
`timescale 1ns / 1ps
// Testbench for sine_pwm_phase_duty_top: drives rotor angle / Uq items and register writes,
// predicts the three compare values in-line and checks each result strobe in order.
// Depends on spwm_pkg and the RTL under hw/rtl.
module tb;
	import spwm_pkg::*;

	typedef longint unsigned u64_t;

	localparam int CYCLE_LIMIT = 200000;
	localparam logic [CFG_IDX_W-1:0] REG_UNUSED_FIRST = 3'd5;
	localparam int ANGLE_MASK_V = (1 << ANGLE_BITS) - 1;
	localparam int RANDOM_PHASES = 6;
	localparam int ITEMS_PER_PHASE = 75;
	localparam int IDLE_PCT = 23;

	localparam longint SINE_ONE_Q30 = 64'sd1073741824;
	localparam longint K1 = 64'sd1686629713;
	localparam longint K3 = 64'sd693598668;
	localparam longint K5 = 64'sd85569304;
	localparam longint K7 = 64'sd5026995;
	localparam longint K9 = 64'sd172273;
	localparam longint ROOT3_Q12 = 64'sd7094;

	logic                   clk = 1'b0;
	logic                   arst_n;
	logic                   start;
	logic                   busy;
	item_t                  item;
	logic                   done;
	result_t                result;
	logic                   cfg_valid;
	logic                   cfg_ready;
	logic [CFG_IDX_W-1:0]   cfg_index;
	logic [CFG_DATA_W-1:0]  cfg_data;

	logic [PPC_W-1:0]       ppc_now;
	logic [VS_W-1:0]        supply_now;
	logic [LIM_W-1:0]       limit_now;
	logic [PER_W-1:0]       period_now;

	result_t pending_compares[$];
	int      mismatch_count = 0;
	int      cycle_count = 0;
	bit      gaps_on = 1'b1;

	sine_pwm_phase_duty_top DUT (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (start),
		.busy      (busy),
		.item      (item),
		.done      (done),
		.result    (result),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count == CYCLE_LIMIT) begin
			$display("TB_ERROR");
			$finish;
		end
	end

	task automatic note_mismatch(input string msg);
		$display("MISMATCH @%0t: %s", $time, msg);
		mismatch_count++;
	endtask

	// signed sine of table index, Q15 with 1.0 = 32768
	function automatic longint sine_q15(input int unsigned k);
		u64_t   pos;
		u64_t   quad;
		u64_t   rem;
		longint u;
		longint u2;
		longint r;
		longint s;
		pos  = u64_t'(k % SINE_TABLE_DEPTH) * 4;
		quad = pos / SINE_TABLE_DEPTH;
		rem  = pos % SINE_TABLE_DEPTH;
		u    = longint'((rem << 30) / SINE_TABLE_DEPTH);
		if (quad[0]) begin
			u = SINE_ONE_Q30 - u;
		end
		u2 = (u * u) >>> 30;
		r  = K9;
		r  = K7 - ((u2 * r) >>> 30);
		r  = K5 - ((u2 * r) >>> 30);
		r  = K3 - ((u2 * r) >>> 30);
		r  = K1 - ((u2 * r) >>> 30);
		s  = (((u * r) >>> 30) + 16384) >>> 15;
		if (s > 32768) begin
			s = 32768;
		end
		return quad[1] ? -s : s;
	endfunction

	// doubled phase voltage at 2^35 per volt -> timer compare
	function automatic logic [PER_W-1:0] compare_from_volts(input longint dbl);
		longint ceiling;
		longint den;
		ceiling = longint'(limit_now) <<< 28;
		den     = longint'(supply_now) <<< 28;
		if (supply_now == '0) begin
			return '0;
		end
		if (dbl < 0) begin
			dbl = 0;
		end
		if (dbl > ceiling) begin
			dbl = ceiling;
		end
		if (dbl >= den) begin
			return period_now;
		end
		return PER_W'((u64_t'(dbl) * u64_t'(period_now) + u64_t'(den) / 2) / u64_t'(den));
	endfunction

	function automatic result_t predict_compares(input item_t it);
		int unsigned elec;
		int unsigned k;
		longint      uq;
		longint      alpha;
		longint      beta_r3;
		longint      vs;
		result_t     res;
		elec    = (int'(ppc_now) * int'(it.rotor_angle)) & ANGLE_MASK_V;
		k       = (elec * SINE_TABLE_DEPTH) >> ANGLE_BITS;
		uq      = longint'($signed(it.quadrature_voltage));
		alpha   = -uq * sine_q15(k) * 4096;
		beta_r3 = uq * sine_q15(k + SINE_TABLE_DEPTH / 4) * ROOT3_Q12;
		vs      = longint'(supply_now) <<< 27;
		res.compare_a = compare_from_volts(2 * alpha + vs);
		res.compare_b = compare_from_volts(beta_r3 - alpha + vs);
		res.compare_c = compare_from_volts(-alpha - beta_r3 + vs);
		return res;
	endfunction

	always @(posedge clk) begin
		result_t want;
		if (arst_n && done) begin
			if (pending_compares.size() == 0) begin
				note_mismatch("result strobe with no item pending");
			end else begin
				want = pending_compares.pop_front();
				if (result.compare_a !== want.compare_a) begin
					note_mismatch($sformatf("compare_a got %0d want %0d",
						result.compare_a, want.compare_a));
				end
				if (result.compare_b !== want.compare_b) begin
					note_mismatch($sformatf("compare_b got %0d want %0d",
						result.compare_b, want.compare_b));
				end
				if (result.compare_c !== want.compare_c) begin
					note_mismatch($sformatf("compare_c got %0d want %0d",
						result.compare_c, want.compare_c));
				end
			end
		end
	end

	task automatic send_item(input logic [ANGLE_BITS-1:0] angle, input logic [UQ_W-1:0] uq);
		item_t it;
		it.rotor_angle        = angle;
		it.quadrature_voltage = uq;
		while (gaps_on && $urandom_range(99) < IDLE_PCT) begin
			start <= 1'b0;
			@(posedge clk);
		end
		start <= 1'b1;
		item  <= it;
		@(posedge clk);
		while (busy) begin
			@(posedge clk);
		end
		pending_compares.push_back(predict_compares(it));
	endtask

	task automatic wait_idle();
		start <= 1'b0;
		while (pending_compares.size() != 0) begin
			@(posedge clk);
		end
		repeat (2) @(posedge clk);
	endtask

	// leaves cfg_valid high; the caller drops it after the last transfer
	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
		if (gaps_on && $urandom_range(99) < IDLE_PCT) begin
			cfg_valid <= 1'b0;
			@(posedge clk);
		end
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= data;
		@(posedge clk);
		while (!cfg_ready) begin
			@(posedge clk);
		end
		unique case (idx)
			REG_POLE_PAIRS:  ppc_now    = data[PPC_W-1:0];
			REG_ELEC_OFFSET: ;
			REG_SUPPLY:      supply_now = data[VS_W-1:0];
			REG_LIMIT:       limit_now  = data[LIM_W-1:0];
			REG_PERIOD:      period_now = data[PER_W-1:0];
			default: ;
		endcase
	endtask

	task automatic load_config(input int ppc, input int ofs, input int vs, input int lim,
			input int per);
		wait_idle();
		write_reg(REG_POLE_PAIRS, CFG_DATA_W'(ppc));
		write_reg(REG_ELEC_OFFSET, CFG_DATA_W'(ofs));
		write_reg(REG_SUPPLY, CFG_DATA_W'(vs));
		write_reg(REG_LIMIT, CFG_DATA_W'(lim));
		write_reg(REG_PERIOD, CFG_DATA_W'(per));
		// undecoded index must be ignored
		write_reg(CFG_IDX_W'(REG_UNUSED_FIRST + $urandom_range(2)),
			CFG_DATA_W'($urandom_range(131071)));
		cfg_valid <= 1'b0;
	endtask

	function automatic int pick_value(input int lo, input int hi);
		unique case ($urandom_range(5))
			0: return lo;
			1: return hi;
			default: return int'($urandom_range(hi, lo));
		endcase
	endfunction

	task automatic test_reset_values();
		send_item(12'd0, 16'd0);
		send_item(12'd0, 16'h7FFF);
		send_item(12'd4095, 16'h8000);
		send_item(12'd585, 16'hFFFF);
		send_item(12'd2048, 16'd1);
		send_item(12'd1024, 16'd1536);
	endtask

	task automatic test_special_cases();
		// zero supply
		load_config(7, 0, 0, 3072, 65536);
		send_item(12'd100, 16'd1000);
		send_item(12'd0, 16'h8000);
		// zero period
		load_config(7, 0, 3072, 3072, 0);
		send_item(12'd300, 16'd1500);
		send_item(12'd4095, -16'sd3000);
		// zero pole pairs
		load_config(0, 0, 3072, 3072, 65536);
		send_item(12'd1234, 16'd2000);
		send_item(12'd4095, -16'sd2000);
		// widest period, limit above supply, max pole pairs and offset
		load_config(127, 4095, 1000, 32767, 131071);
		send_item(12'd4095, 16'h7FFF);
		send_item(12'd1, 16'd500);
		send_item(12'd2048, -16'sd700);
		// zero limit, max supply, unit period
		load_config(64, 2048, 32767, 0, 1);
		send_item(12'd512, 16'h8000);
		send_item(12'd3000, 16'h7FFF);
		// smallest supply and limit
		load_config(1, 1, 1, 1, 65535);
		send_item(12'd0, 16'd0);
		send_item(12'd1024, 16'd1);
	endtask

	task automatic test_random_configs();
		int vs_i;
		int q;
		for (int ph = 0; ph < RANDOM_PHASES; ph++) begin
			load_config(ph < 3 ? pick_value(1, 64) : pick_value(0, 127),
				pick_value(0, 4095), pick_value(1, 32767), pick_value(0, 32767),
				ph % 2 ? pick_value(0, 131071) : pick_value(1, 65536));
			gaps_on = (ph != 3);
			vs_i = int'(supply_now);
			for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
				if ($urandom_range(3) == 0) begin
					q = int'($urandom_range(65535));
				end else begin
					q = int'($urandom_range(2 * vs_i)) - vs_i;
				end
				send_item(ANGLE_BITS'($urandom_range(4095)), UQ_W'(q));
			end
		end
		gaps_on = 1'b1;
	endtask

	initial begin
		arst_n     <= 1'b0;
		start      <= 1'b0;
		item       <= '0;
		cfg_valid  <= 1'b0;
		cfg_index  <= '0;
		cfg_data   <= '0;
		ppc_now    = PPC_RESET;
		supply_now = VS_RESET;
		limit_now  = LIM_RESET;
		period_now = PER_RESET;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_reset_values();
		test_special_cases();
		test_random_configs();

		wait_idle();
		repeat (PIPE_LATENCY + 4) @(posedge clk);
		if (mismatch_count == 0) begin
			$display("TB_OK");
		end else begin
			$display("TB_ERROR");
		end
		$finish;
	end

endmodule

[files.f]
hw/rtl/spwm_pkg.sv
hw/rtl/spwm_cfg.sv
hw/rtl/spwm_front.sv
hw/rtl/spwm_phase.sv
hw/rtl/spwm_div.sv
hw/rtl/sine_pwm_phase_duty_top.sv
hw/rtl/spwm_chk.sv
tb/sv/tb.sv
